@@ hdl/avcd_pkg.sv @@
// Shared types and constants for the AVI chunk demuxer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package avcd_pkg;

   // Four-character codes, first character in the top byte
   localparam logic [31:0] ID_RIFF  = 32'h5249_4646;
   localparam logic [31:0] ID_LIST  = 32'h4C49_5354;
   localparam logic [31:0] ID_MOVI  = 32'h6D6F_7669;
   localparam logic [31:0] ID_STRH  = 32'h7374_7268;
   localparam logic [31:0] ID_AUDS  = 32'h6175_6473;
   localparam logic [31:0] ID_VIDEO = 32'h3030_6463;
   localparam logic [31:0] ID_AUDIO = 32'h3031_7762;

   // Largest sample frame the fill counter can track
   localparam logic [6:0] SAMPLE_MAX = 7'd64;

   // Register map
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BYTES      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_SAMPLE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUDIO_WANTED     = 8'd2;

   // Route codes on the result channel
   localparam logic [1:0] ROUTE_DROP  = 2'd0;
   localparam logic [1:0] ROUTE_VIDEO = 2'd1;
   localparam logic [1:0] ROUTE_AUDIO = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LISTTYPE,
      PH_STRHTYPE,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_VIDEO,
      KIND_AUDIO
   } kind_type;

   typedef struct packed {
      logic [31:0] frame_bytes;
      logic [6:0]  bytes_per_sample;
      logic        audio_wanted;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] route;
      logic       frame_done;
      logic       sample_done;
      logic       audio_start;
   } result_type;

endpackage

@@ hdl/avcd_csr.sv @@
// Configuration registers of the AVI chunk demuxer.
// Depends on avcd_pkg for the register map and the cfg_type struct.
`timescale 1ns / 1ps

module avcd_csr
   import avcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_BYTES:      cfg_in.frame_bytes      = csr_wdata[31:0];
            CSR_BYTES_PER_SAMPLE: cfg_in.bytes_per_sample = csr_wdata[6:0];
            CSR_AUDIO_WANTED:     cfg_in.audio_wanted     = csr_wdata[0];
            default:              cfg_in = cfg_ff;  // drop writes off the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_bytes      <= 32'd0;
         cfg_ff.bytes_per_sample <= 7'd8;
         cfg_ff.audio_wanted     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/avcd_walker.sv @@
// Chunk walker: per-byte parse state and the result for each accepted byte.
// Depends on avcd_pkg for phases, kinds, fourcc codes and the structs.
`timescale 1ns / 1ps

module avcd_walker
   import avcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] stream_byte,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [31:0] chunk_id_ff, chunk_id_in;
   logic [31:0] chunk_size_ff, chunk_size_in;
   logic [32:0] bytes_left_ff, bytes_left_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [31:0] type_word_ff, type_word_in;
   logic        audio_seen_ff, audio_seen_in;
   logic        headers_done_ff, headers_done_in;
   logic        audio_active_ff, audio_active_in;
   logic [5:0]  sample_fill_ff, sample_fill_in;

   logic [3:0]  count_inc;
   logic [31:0] type_next;
   logic [32:0] strh_padded;
   logic [32:0] strh_left;
   logic [32:0] hdr_padded;
   logic [6:0]  sample_eff;
   logic [6:0]  fill_inc;
   logic        last_byte;
   result_type  res;

   assign count_inc   = header_count_ff + 4'd1;
   assign type_next   = {type_word_ff[23:0], stream_byte};
   assign strh_padded = {1'b0, chunk_size_ff} + {32'd0, chunk_size_ff[0]};
   assign strh_left   = strh_padded - 33'd4;
   assign hdr_padded  = {1'b0, chunk_size_in} + {32'd0, chunk_size_in[0]};
   assign sample_eff  = (cfg.bytes_per_sample > SAMPLE_MAX) ? SAMPLE_MAX
                                                             : cfg.bytes_per_sample;
   assign fill_inc    = {1'b0, sample_fill_ff} + 7'd1;
   assign last_byte   = (bytes_left_ff == 33'd1);

   always_comb begin
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      chunk_id_in     = chunk_id_ff;
      chunk_size_in   = chunk_size_ff;
      bytes_left_in   = bytes_left_ff;
      header_count_in = header_count_ff;
      type_word_in    = type_word_ff;
      audio_seen_in   = audio_seen_ff;
      headers_done_in = headers_done_ff;
      audio_active_in = audio_active_ff;
      sample_fill_in  = sample_fill_ff;
      res             = '0;
      res.data_byte   = stream_byte;
      res.route       = ROUTE_DROP;

      if (phase_ff == PH_LISTTYPE || phase_ff == PH_STRHTYPE) begin
         type_word_in    = type_next;
         header_count_in = count_inc;
         if (count_inc >= 4'd4) begin
            header_count_in = 4'd0;
            if (phase_ff == PH_LISTTYPE) begin
               phase_in = PH_HEADER;
               // first movi list closes the header section
               if (type_next == ID_MOVI && !headers_done_ff) begin
                  headers_done_in = 1'b1;
                  if (audio_seen_ff && cfg.audio_wanted) begin
                     audio_active_in = 1'b1;
                     res.audio_start = 1'b1;
                  end
               end
            end else begin
               if (type_next == ID_AUDS) begin
                  audio_seen_in = 1'b1;
               end
               // skip the rest of the strh chunk
               if (strh_left == 33'd0) begin
                  phase_in = PH_HEADER;
               end else begin
                  kind_in       = KIND_SKIP;
                  bytes_left_in = strh_left;
                  phase_in      = PH_BODY;
               end
            end
         end
      end else if (phase_ff == PH_BODY && bytes_left_ff != 33'd0) begin
         bytes_left_in = bytes_left_ff - 33'd1;
         case (kind_ff)
            KIND_VIDEO: begin
               res.route      = ROUTE_VIDEO;
               res.frame_done = last_byte;
            end
            KIND_AUDIO: begin
               res.route = ROUTE_AUDIO;
               if (sample_eff != 7'd0) begin
                  if (fill_inc >= sample_eff) begin
                     res.sample_done = 1'b1;
                     sample_fill_in  = 6'd0;
                  end else begin
                     sample_fill_in = fill_inc[5:0];
                  end
               end
            end
            default: res.route = ROUTE_DROP;
         endcase
         if (last_byte) begin
            // odd payload: one pad byte follows, dropped
            if (kind_ff != KIND_SKIP && chunk_size_ff[0]) begin
               kind_in       = KIND_SKIP;
               bytes_left_in = 33'd1;
            end else begin
               phase_in = PH_HEADER;
            end
         end
      end else begin
         phase_in = PH_HEADER;
         if (header_count_ff < 4'd4) begin
            chunk_id_in = {chunk_id_ff[23:0], stream_byte};
         end else begin
            chunk_size_in = {stream_byte, chunk_size_ff[31:8]};
         end
         header_count_in = count_inc;
         if (count_inc >= 4'd8) begin
            header_count_in = 4'd0;
            if (chunk_id_in == ID_RIFF || chunk_id_in == ID_LIST) begin
               phase_in = PH_LISTTYPE;
            end else if (chunk_id_in == ID_STRH && chunk_size_in >= 32'd4) begin
               phase_in = PH_STRHTYPE;
            end else if (chunk_id_in == ID_VIDEO && chunk_size_in == cfg.frame_bytes) begin
               if (chunk_size_in == 32'd0) begin
                  // empty frame completes on its header
                  res.frame_done = 1'b1;
               end else begin
                  kind_in       = KIND_VIDEO;
                  bytes_left_in = {1'b0, chunk_size_in};
                  phase_in      = PH_BODY;
               end
            end else if (chunk_id_in == ID_AUDIO && audio_active_ff
                         && cfg.bytes_per_sample != 7'd0) begin
               if (chunk_size_in != 32'd0) begin
                  kind_in       = KIND_AUDIO;
                  bytes_left_in = {1'b0, chunk_size_in};
                  phase_in      = PH_BODY;
               end
            end else if (hdr_padded != 33'd0) begin
               kind_in       = KIND_SKIP;
               bytes_left_in = hdr_padded;
               phase_in      = PH_BODY;
            end
         end
      end
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         kind_ff         <= KIND_SKIP;
         chunk_id_ff     <= 32'd0;
         chunk_size_ff   <= 32'd0;
         bytes_left_ff   <= 33'd0;
         header_count_ff <= 4'd0;
         type_word_ff    <= 32'd0;
         audio_seen_ff   <= 1'b0;
         headers_done_ff <= 1'b0;
         audio_active_ff <= 1'b0;
         sample_fill_ff  <= 6'd0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         kind_ff         <= kind_in;
         chunk_id_ff     <= chunk_id_in;
         chunk_size_ff   <= chunk_size_in;
         bytes_left_ff   <= bytes_left_in;
         header_count_ff <= header_count_in;
         type_word_ff    <= type_word_in;
         audio_seen_ff   <= audio_seen_in;
         headers_done_ff <= headers_done_in;
         audio_active_ff <= audio_active_in;
         sample_fill_ff  <= sample_fill_in;
      end
   end

   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> bytes_left_ff != 33'd0)
      else $error("body phase with nothing left");

   a_type_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LISTTYPE || phase_ff == PH_STRHTYPE) |-> header_count_ff < 4'd4)
      else $error("type word count overran");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> header_count_ff < 4'd8)
      else $error("header count overran");

   a_start_once: assert property (@(posedge clock) disable iff (reset)
      headers_done_ff |-> !res.audio_start)
      else $error("audio start after header section closed");

   a_active_after_start: assert property (@(posedge clock) disable iff (reset)
      advance && res.audio_start |=> audio_active_ff && headers_done_ff)
      else $error("audio start did not activate audio");

endmodule

@@ hdl/avi_chunk_demuxer.sv @@
// AVI chunk demuxer, top level: walker, configuration registers, result register.
// Depends on avcd_pkg, avcd_csr and avcd_walker.
// Usage:
//   req_ channel: one stream byte per word, taken when req_valid is high and
//     req_stall is low.
//   rsp_ channel: one word per input byte, the byte itself with its route
//     (drop, video, audio) and the frame, sample and audio start markers.
//   csr_ channel: register writes (0 frame_bytes, 1 bytes_per_sample,
//     2 audio_wanted), always ready; write only while no byte is in flight.
// The result is registered: a byte taken at one edge shows on rsp_ after it.
// Throughput is one byte per cycle unless the receiver stalls; the parse state
// updates in a single pass per byte and the result register frees as the receiver
// takes its word. When the receiver stalls, the result register holds and req_stall
// rises, so no byte is taken until the waiting word leaves.
// Reset puts the walker at the start of a chunk header, clears audio state,
// empties the result register and loads the register defaults
// (frame_bytes 0, bytes_per_sample 8, audio_wanted 1).
`timescale 1ns / 1ps

module avi_chunk_demuxer
   import avcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_stream_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_data_byte,
   output logic [1:0]             rsp_route,
   output logic                   rsp_frame_done,
   output logic                   rsp_sample_done,
   output logic                   rsp_audio_start,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   avcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   avcd_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .stream_byte (req_stream_byte),
      .cfg         (cfg),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload loads only with a new word, so a stalled word holds
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_byte   = rsp_ff.data_byte;
   assign rsp_route       = rsp_ff.route;
   assign rsp_frame_done  = rsp_ff.frame_done;
   assign rsp_sample_done = rsp_ff.sample_done;
   assign rsp_audio_start = rsp_ff.audio_start;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !accept)
      else $error("waiting word overwritten");

   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted byte produced no word");

   a_route_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.route != 2'd3)
      else $error("undefined route code");

endmodule

@@ tb/sv/avi_chunk_demuxer_test.sv @@
// Self-checking testbench for avi_chunk_demuxer: drives AVI chunk streams on req_,
// predicts every rsp_ word with a chunk walker of its own and checks it field by field.
// Depends on avcd_pkg and the avi_chunk_demuxer RTL.
`timescale 1ns / 1ps

module avi_chunk_demuxer_test;
   import avcd_pkg::*;

   localparam logic [31:0] ID_JUNK = 32'h4A55_4E4B;
   localparam logic [31:0] ID_AVI  = 32'h4156_4920;
   localparam logic [31:0] ID_HDRL = 32'h6864_726C;
   localparam logic [31:0] ID_VIDS = 32'h7669_6473;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_stream_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_data_byte;
   logic [1:0]             rsp_route;
   logic                   rsp_frame_done;
   logic                   rsp_sample_done;
   logic                   rsp_audio_start;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   avi_chunk_demuxer u_top (.*);

   initial forever #1 clock = ~clock;

   logic [7:0] stream_q[$];
   result_type demux_q[$];
   int failures = 0;
   int bytes_queued = 0;
   int req_gap = 0;
   int stall_left = 0;
   bit req_taken = 1'b0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   // Chunk walker state
   cfg_type     regs;
   phase_type   walk_phase;
   kind_type    walk_kind;
   logic [31:0] walk_id;
   logic [31:0] walk_size;
   logic [31:0] walk_type;
   logic [32:0] walk_left;
   logic [3:0]  walk_count;
   logic [5:0]  sample_fill;
   bit          seen_auds;
   bit          movi_found;
   bit          audio_on;

   function automatic void start_body(input kind_type kind, input logic [32:0] len);
      if (len == 0) begin
         walk_phase = PH_HEADER;
      end else begin
         walk_kind = kind;
         walk_left = len;
         walk_phase = PH_BODY;
      end
   endfunction

   function automatic result_type demux_byte(input logic [7:0] b);
      result_type r;
      logic [32:0] padded;
      logic [6:0]  per_sample;
      r = '0;
      r.data_byte = b;
      r.route = ROUTE_DROP;
      if (walk_phase == PH_LISTTYPE || walk_phase == PH_STRHTYPE) begin
         walk_type = {walk_type[23:0], b};
         walk_count++;
         if (walk_count >= 4) begin
            walk_count = '0;
            if (walk_phase == PH_LISTTYPE) begin
               walk_phase = PH_HEADER;
               if (walk_type == ID_MOVI && !movi_found) begin
                  movi_found = 1'b1;
                  if (seen_auds && regs.audio_wanted) begin
                     audio_on = 1'b1;
                     r.audio_start = 1'b1;
                  end
               end
            end else begin
               padded = {1'b0, walk_size} + walk_size[0];
               if (walk_type == ID_AUDS) seen_auds = 1'b1;
               start_body(KIND_SKIP, padded - 33'd4);
            end
         end
      end else if (walk_phase == PH_BODY && walk_left != 0) begin
         walk_left--;
         if (walk_kind == KIND_VIDEO) begin
            r.route = ROUTE_VIDEO;
            r.frame_done = (walk_left == 0);
         end else if (walk_kind == KIND_AUDIO) begin
            per_sample = (regs.bytes_per_sample > SAMPLE_MAX) ? SAMPLE_MAX
                                                               : regs.bytes_per_sample;
            r.route = ROUTE_AUDIO;
            // a zero sample size holds the fill
            if (per_sample != 0) begin
               if ({1'b0, sample_fill} + 7'd1 >= per_sample) begin
                  r.sample_done = 1'b1;
                  sample_fill = '0;
               end else begin
                  sample_fill++;
               end
            end
         end
         if (walk_left == 0) begin
            if (walk_kind != KIND_SKIP && walk_size[0]) begin
               walk_kind = KIND_SKIP;
               walk_left = 33'd1;
            end else begin
               walk_phase = PH_HEADER;
            end
         end
      end else begin
         walk_phase = PH_HEADER;
         if (walk_count < 4) walk_id = {walk_id[23:0], b};
         else walk_size = {b, walk_size[31:8]};
         walk_count++;
         if (walk_count >= 8) begin
            // header complete: decide what the payload becomes
            walk_count = '0;
            padded = {1'b0, walk_size} + walk_size[0];
            if (walk_id == ID_RIFF || walk_id == ID_LIST) begin
               walk_phase = PH_LISTTYPE;
            end else if (walk_id == ID_STRH && walk_size >= 4) begin
               walk_phase = PH_STRHTYPE;
            end else if (walk_id == ID_VIDEO && walk_size == regs.frame_bytes) begin
               if (walk_size == 0) begin
                  r.frame_done = 1'b1;
                  walk_phase = PH_HEADER;
               end else begin
                  start_body(KIND_VIDEO, {1'b0, walk_size});
               end
            end else if (walk_id == ID_AUDIO && audio_on && regs.bytes_per_sample != 0) begin
               start_body(KIND_AUDIO, {1'b0, walk_size});
            end else begin
               start_body(KIND_SKIP, padded);
            end
         end
      end
      return r;
   endfunction

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // Sample handshakes, keep the walker in step and check results
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         regs.frame_bytes = 32'd0;
         regs.bytes_per_sample = 7'd8;
         regs.audio_wanted = 1'b1;
         walk_phase = PH_HEADER;
         walk_kind = KIND_SKIP;
         walk_id = '0;
         walk_size = '0;
         walk_type = '0;
         walk_left = '0;
         walk_count = '0;
         sample_fill = '0;
         seen_auds = 1'b0;
         movi_found = 1'b0;
         audio_on = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_BYTES:      regs.frame_bytes = csr_wdata;
               CSR_BYTES_PER_SAMPLE: regs.bytes_per_sample = csr_wdata[6:0];
               CSR_AUDIO_WANTED:     regs.audio_wanted = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            demux_q.push_back(demux_byte(req_stream_byte));
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (demux_q.size() == 0) begin
               $error("result word with no byte outstanding: %0h", rsp_data_byte);
               failures++;
            end else begin
               want = demux_q.pop_front();
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
               check_field("route", 32'(want.route), 32'(rsp_route));
               check_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
               check_field("sample_done", 32'(want.sample_done), 32'(rsp_sample_done));
               check_field("audio_start", 32'(want.audio_start), 32'(rsp_audio_start));
            end
         end
      end
   end

   // Byte driver: hold the word until taken, then idle or advance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken && !req_quiet) req_gap = idle_len();
         req_taken = 1'b0;
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (stream_q.size() != 0) begin
            req_valid <= 1'b1;
            req_stream_byte <= stream_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver stalls
   always @(negedge clock) begin
      if (reset || rsp_quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_len();
      end
   end

   task automatic put_byte(input logic [7:0] b);
      stream_q.push_back(b);
      bytes_queued++;
   endtask

   task automatic put_id(input logic [31:0] id);
      put_byte(id[31:24]);
      put_byte(id[23:16]);
      put_byte(id[15:8]);
      put_byte(id[7:0]);
   endtask

   task automatic put_size(input logic [31:0] size);
      put_byte(size[7:0]);
      put_byte(size[15:8]);
      put_byte(size[23:16]);
      put_byte(size[31:24]);
   endtask

   task automatic put_payload(input int n);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic put_chunk(input logic [31:0] id, input logic [31:0] size);
      put_id(id);
      put_size(size);
      put_payload(size + size[0]);
   endtask

   task automatic put_list(input logic [31:0] id, input logic [31:0] list_type);
      put_id(id);
      put_size($urandom());
      put_id(list_type);
   endtask

   task automatic put_strh(input logic [31:0] size, input logic [31:0] stream_type);
      put_id(ID_STRH);
      put_size(size);
      if (size >= 4) begin
         put_id(stream_type);
         put_payload(size - 4 + size[0]);
      end else begin
         put_payload(size + size[0]);
      end
   endtask

   // Mostly well-formed chunks, some near-miss ids and wrong sizes
   task automatic put_random_chunk(input int frame_len);
      int pick;
      logic [31:0] size;
      logic [31:0] id;
      pick = $urandom_range(0, 99);
      size = $urandom_range(0, 14);
      if (pick < 30) begin
         put_chunk(ID_VIDEO, frame_len);
      end else if (pick < 55) begin
         put_chunk(ID_AUDIO, size);
      end else if (pick < 62) begin
         put_chunk(ID_VIDEO, size);
      end else if (pick < 68) begin
         put_strh(size, $urandom_range(0, 1) ? ID_AUDS : $urandom());
      end else if (pick < 74) begin
         put_list($urandom_range(0, 1) ? ID_LIST : ID_RIFF,
                  $urandom_range(0, 1) ? ID_MOVI : $urandom());
      end else if (pick < 86) begin
         case ($urandom_range(0, 2))
            0: id = ID_VIDEO;
            1: id = ID_AUDIO;
            default: id = ID_STRH;
         endcase
         id = id ^ (32'd1 << $urandom_range(0, 31));
         put_chunk(id, size);
      end else begin
         do id = $urandom(); while (id == ID_RIFF || id == ID_LIST);
         put_chunk(id, size);
      end
   endtask

   // Wait until every queued byte is taken and every word is back
   task automatic settle();
      while (stream_q.size() != 0 || req_valid || demux_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_no;
      int frame_len;
      int sample_len;
      int stop_at;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // header lists, zero-length frame at the reset frame size, short and odd strh
      put_list(ID_RIFF, ID_AVI);
      put_list(ID_LIST, ID_HDRL);
      put_chunk(ID_VIDEO, 0);
      put_strh(3, ID_AUDS);
      put_strh(9, ID_VIDS);
      put_chunk(ID_JUNK, 5);
      settle();
      write_reg(CSR_AUDIO_WANTED, 0);
      write_reg(CSR_FRAME_BYTES, 7);
      write_reg(8'hFF, 32'hFFFF_FFFF);
      put_strh(4, ID_AUDS);
      put_chunk(ID_VIDEO, 7);
      put_chunk(ID_AUDIO, 3);
      settle();
      write_reg(CSR_AUDIO_WANTED, 1);
      put_list(ID_LIST, ID_MOVI);
      put_chunk(ID_AUDIO, 5);
      put_chunk(ID_VIDEO, 7);
      put_chunk(ID_VIDEO, 6);
      settle();
      write_reg(CSR_BYTES_PER_SAMPLE, 64);
      put_chunk(ID_AUDIO, 10);
      settle();
      // fill is already past the new sample size
      write_reg(CSR_BYTES_PER_SAMPLE, 4);
      put_chunk(ID_AUDIO, 6);
      settle();
      // change the sample size twice inside one odd audio chunk
      write_reg(CSR_BYTES_PER_SAMPLE, 2);
      put_id(ID_AUDIO);
      put_size(9);
      put_payload(4);
      settle();
      write_reg(CSR_BYTES_PER_SAMPLE, 0);
      put_payload(3);
      settle();
      write_reg(CSR_BYTES_PER_SAMPLE, 127);
      put_payload(3);
      put_list(ID_LIST, ID_MOVI);
      settle();

      for (phase_no = 0; phase_no < 6; phase_no++) begin
         frame_len = (phase_no == 0) ? 1 : $urandom_range(0, 12);
         case (phase_no)
            0: sample_len = 1;
            1: sample_len = 0;
            2: sample_len = 127;
            default: sample_len = $urandom_range(2, 20);
         endcase
         write_reg(CSR_FRAME_BYTES, frame_len);
         write_reg(CSR_BYTES_PER_SAMPLE, sample_len);
         write_reg(CSR_AUDIO_WANTED, $urandom_range(0, 1));
         write_reg(CSR_INDEX_W'($urandom_range(3, 255)), $urandom());
         req_quiet = (phase_no == 1 || phase_no == 4);
         rsp_quiet = (phase_no == 3 || phase_no == 4);
         stop_at = bytes_queued + 70;
         while (bytes_queued < stop_at) put_random_chunk(frame_len);
         settle();
      end

      // full-width frame size: the frame never ends, every byte stays video
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      write_reg(CSR_FRAME_BYTES, 32'hFFFF_FFFF);
      put_id(ID_VIDEO);
      put_size(32'hFFFF_FFFF);
      put_payload(40);
      settle();
      repeat (10) @(posedge clock);
      if (demux_q.size() != 0) begin
         $error("%0d result words never arrived", demux_q.size());
         failures++;
      end
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
